/* src/look_disk_request_scheduler_assert.svh */
// Assertion macros used by the checker file.
`ifndef LOOK_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define LOOK_DISK_REQUEST_SCHEDULER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LDRS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LDRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/ldrs_pkg.sv */
package ldrs_pkg;
   localparam int CountWidth = 5;

   // Values of the action field of an input item.
   localparam logic ActArrive   = 1'b0;
   localparam logic ActComplete = 1'b1;

   // One request as held in the queue and in the active slot.
   typedef struct packed {
      logic [15:0] id;
      logic [31:0] arrival_time;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] process;
   } entry_type;

   typedef struct packed {
      logic        action;
      logic [15:0] req_id;
      logic [31:0] req_arrival_time;
      logic [15:0] req_cylinder;
      logic [31:0] req_address;
      logic [15:0] req_process;
      logic [15:0] head_cylinder;
      logic        scan_up;
   } req_type;

   typedef struct packed {
      logic [15:0] out_id;
      logic [31:0] out_arrival_time;
      logic [15:0] out_cylinder;
      logic [31:0] out_address;
      logic [15:0] out_process;
      logic        dropped;
      logic [CountWidth-1:0] pending_count;
   } rsp_type;

   // Best candidate so far, passed from cell to cell during a scan.
   // rank: 0 same cylinder, 1 in scan direction, 2 other direction.
   typedef struct packed {
      logic        found;
      logic [1:0]  rank;
      logic [16:0] gap;
      logic [31:0] arrival_time;
   } cand_type;

   // Commands from the sequencer to the cell row.
   localparam logic [1:0] CmdHold  = 2'd0;
   localparam logic [1:0] CmdScan  = 2'd1;
   localparam logic [1:0] CmdShift = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] head;
      logic        scan_up;
   } ctl_type;
endpackage

/* src/ldrs_cell.sv */
// One queue slot. During a scan the best candidate moves through the row one
// cell per cycle; each cell compares its entry against it. During a shift every
// cell at or behind the chosen slot takes its right neighbor's entry.
module ldrs_cell
   import ldrs_pkg::*;
(
   input  logic      clock,
   input  ctl_type   ctl,
   input  logic      write_en,
   input  entry_type write_data,
   input  logic      occupied,
   input  logic      shift_en,
   input  entry_type next_entry,
   input  cand_type  cand_in,
   output cand_type  cand_out,
   output logic      take_out,
   output entry_type entry_out
);
   entry_type   entry_ff;
   logic [16:0] gap;
   logic [1:0]  rank;
   logic        better;

   // Rank and distance of this entry against the head.
   always_comb begin
      if (entry_ff.cylinder == ctl.head) begin
         rank = 2'd0;
         gap = 17'd0;
      end else if ((entry_ff.cylinder > ctl.head) == ctl.scan_up) begin
         rank = 2'd1;
         gap = (entry_ff.cylinder > ctl.head)
            ? {1'b0, entry_ff.cylinder - ctl.head}
            : {1'b0, ctl.head - entry_ff.cylinder};
      end else begin
         rank = 2'd2;
         gap = (entry_ff.cylinder > ctl.head)
            ? {1'b0, entry_ff.cylinder - ctl.head}
            : {1'b0, ctl.head - entry_ff.cylinder};
      end
      better = occupied && (!cand_in.found || rank < cand_in.rank ||
         (rank == cand_in.rank && (gap < cand_in.gap ||
         (gap == cand_in.gap && entry_ff.arrival_time < cand_in.arrival_time))));
   end

   // Registered candidate hand-off to the next cell.
   always_ff @(posedge clock) begin
      cand_out <= better ? cand_type'{1'b1, rank, gap, entry_ff.arrival_time}
                         : cand_in;
      take_out <= better;
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= write_data;
      end else if (ctl.cmd == CmdShift && shift_en) begin
         entry_ff <= next_entry;
      end
   end

   assign entry_out = entry_ff;
endmodule

/* src/look_disk_request_scheduler.sv */
// LOOK disk request scheduler. An arrival shows its result in the cycle after
// acceptance, as does a completion with an empty queue. Any other completion
// first scans: the best candidate walks the cell row one cell per cycle; then
// the queue closes the gap in the shift state and the result follows.
// One item is worked at a time; the block returns to idle the cycle after the
// result is taken.
module look_disk_request_scheduler
   import ldrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int IdxWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int StepWidth = $clog2(QUEUE_DEPTH + 2);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StScan  = 2'd1;
   localparam logic [1:0] StShift = 2'd2;
   localparam logic [1:0] StOut   = 2'd3;

   logic [1:0]           state_ff;
   logic [CntWidth-1:0]  count_ff;
   logic [StepWidth-1:0] step_ff;
   logic [IdxWidth-1:0]  best_ff;
   entry_type            active_ff;
   logic                 dropped_ff;
   req_type              item_ff;
   ctl_type              ctl;

   cand_type  cand [QUEUE_DEPTH+1];
   logic      take [QUEUE_DEPTH];
   entry_type entries [QUEUE_DEPTH+1];
   logic      accept;
   logic      active_null;
   entry_type new_entry;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == StIdle);
   assign active_null = (active_ff == '0);
   assign new_entry = entry_type'{req_data.req_id, req_data.req_arrival_time,
      req_data.req_cylinder, req_data.req_address, req_data.req_process};
   assign cand[0] = '0;
   assign entries[QUEUE_DEPTH] = '0;

   always_comb begin
      ctl.head = item_ff.head_cylinder;
      ctl.scan_up = item_ff.scan_up;
      case (state_ff)
         StScan:  ctl.cmd = CmdScan;
         StShift: ctl.cmd = CmdShift;
         default: ctl.cmd = CmdHold;
      endcase
   end

   // Row of queue cells; the candidate chain is registered between cells.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      ldrs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .write_en   (accept && req_data.action == ActArrive && !active_null &&
                      count_ff == CntWidth'(g)),
         .write_data (new_entry),
         .occupied   (CntWidth'(g) < count_ff),
         .shift_en   (IdxWidth'(g) >= best_ff),
         .next_entry (entries[g+1]),
         .cand_in    (cand[g]),
         .cand_out   (cand[g+1]),
         .take_out   (take[g]),
         .entry_out  (entries[g])
      );
   end

   // Sequencer: the step counter follows the candidate down the row.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         count_ff   <= '0;
         active_ff  <= '0;
         dropped_ff <= 1'b0;
         step_ff    <= '0;
         best_ff    <= '0;
      end else begin
         case (state_ff)
            StIdle: begin
               if (accept) begin
                  item_ff    <= req_data;
                  dropped_ff <= 1'b0;
                  step_ff    <= '0;
                  best_ff    <= '0;
                  if (req_data.action == ActArrive) begin
                     state_ff <= StOut;
                     if (active_null) begin
                        active_ff <= new_entry;
                     end else if (count_ff < CntWidth'(QUEUE_DEPTH)) begin
                        count_ff <= count_ff + 1'b1;
                     end else begin
                        dropped_ff <= 1'b1;
                     end
                  end else if (count_ff == '0) begin
                     active_ff <= '0;
                     state_ff  <= StOut;
                  end else begin
                     state_ff <= StScan;
                  end
               end
            end
            StScan: begin
               // take[k] is valid in the cycle after cell k saw the candidate.
               if (step_ff != '0 && take[IdxWidth'(step_ff - 1'b1)]) begin
                  best_ff <= IdxWidth'(step_ff - 1'b1);
               end
               if (step_ff == StepWidth'(QUEUE_DEPTH)) begin
                  state_ff <= StShift;
               end
               step_ff <= step_ff + 1'b1;
            end
            StShift: begin
               active_ff <= entries[best_ff];
               count_ff  <= count_ff - 1'b1;
               state_ff  <= StOut;
            end
            StOut: begin
               if (rsp_ready) begin
                  state_ff <= StIdle;
               end
            end
            default: state_ff <= StIdle;
         endcase
      end
   end

   assign rsp_valid = (state_ff == StOut);
   assign rsp_data = rsp_type'{active_ff.id, active_ff.arrival_time,
      active_ff.cylinder, active_ff.address, active_ff.process, dropped_ff,
      CountWidth'(count_ff)};
endmodule

/* src/ldrs_checker.sv */
// Port-level checks of the scheduler.
`include "look_disk_request_scheduler_assert.svh"
module ldrs_checker
   import ldrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // One item at a time: no new item while a result is shown.
   `LDRS_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, !req_ready)
   // A result stays until taken.
   `LDRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // A drop happens only while a request is active, so a dropped result is never null.
   `LDRS_ASSERT_IMP(a_drop_busy, clock, reset, rsp_valid && rsp_data.dropped,
      (rsp_data.out_id != '0) || (rsp_data.out_arrival_time != '0) || (rsp_data.out_cylinder != '0) || (rsp_data.out_address != '0) || (rsp_data.out_process != '0))
   // An accepted item blocks input on the next cycle.
   `LDRS_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind look_disk_request_scheduler ldrs_checker u_ldrs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
